// File: sv/mrr_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-reader overwrite ring: field widths, mode and status codes,
// controller states and the transaction payload types. No dependencies.
package mrr_pkg;

  localparam int MODE_W    = 2;
  localparam int READER_W  = 3;
  localparam int WDATA_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int RDATA_W   = 8;
  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 13;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [COUNT_W-1:0] RING_LENGTH_RESET = 13'd4096;
  localparam logic [CFG_AW-1:0]  ADDR_RING_LENGTH  = 3'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_ATTACH = 2'd2,
    MODE_DETACH = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_NOT_ATT = 2'd2,
    ST_NO_SLOT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    mode_t                mode;
    logic [READER_W-1:0]  reader;
    logic [WDATA_W-1:0]   write_data;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [RDATA_W-1:0]   read_data;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   pending;
    logic [COUNT_W-1:0]   fill;
  } out_item_t;

endpackage

// File: sv/mrr_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of type T per transaction.
// Used by the ring for its input and result channels; no dependencies.
interface mrr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/multi_reader_overwrite_ring.sv
`timescale 1ns / 1ps
// Multi-reader overwrite ring: one writer, READERS reader slots over a ring in one RAM.
// Depends on mrr_pkg and mrr_stream_if.
//
// Each transaction takes one mode (write, read, attach, detach) and returns exactly one
// result. Items are processed one at a time: accept, an execute state with the single
// RAM access, then the result goes to an output register; a read that returns data
// also passes through a serial scan over all READERS slots that finds the largest reader
// backlog, which sets the ring fill. The next item is accepted while a result
// still waits in the output register. The RAM needs no clearing pass; entries never
// written read as undefined. ring_length is clamped to 2..DEPTH and is written at
// byte address 0 of the APB port.
module multi_reader_overwrite_ring #(
  parameter int DEPTH      = 4096,
  parameter int READERS    = 8,
  parameter int DATA_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mrr_stream_if.sink                  in_ch,
  mrr_stream_if.source                out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrr_pkg::CFG_AW-1:0]  paddr,
  input  logic [mrr_pkg::CFG_DW-1:0]  pwdata,
  output logic [mrr_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import mrr_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int LW  = $clog2(DEPTH + 1);
  localparam int LW1 = LW + 1;
  localparam int CW  = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int RIW = (READERS > 1) ? $clog2(READERS) : 1;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [LW-1:0] l);
    logic [LW1-1:0] nx;
    nx  = LW1'(p) + LW1'(1);
    adv = (nx >= LW1'(l)) ? '0 : AW'(nx);
  endfunction

  state_t                state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [LW-1:0]         fill_r, fill_nxt;
  logic                  att_r [READERS];
  logic                  att_nxt [READERS];
  logic [AW-1:0]         ptr_r [READERS];
  logic [AW-1:0]         ptr_nxt [READERS];
  logic [LW-1:0]         bl_r [READERS];
  logic [LW-1:0]         bl_nxt [READERS];
  logic [COUNT_W-1:0]    ring_length_r, ring_length_nxt;
  logic [RIW-1:0]        scan_idx_r, scan_idx_nxt;
  logic [LW-1:0]         best_r, best_nxt;
  status_t               status_r, status_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [RIW-1:0]        pidx_r, pidx_nxt;
  logic                  pvalid_r, pvalid_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic [CW-1:0]         len_ext;
  logic [LW-1:0]         len;
  logic                  r_valid;
  logic [RIW-1:0]        rsel;
  logic                  free_any;
  logic [RIW-1:0]        free_idx;
  logic [LW-1:0]         cand;
  logic                  cfg_wr;

  assign len_ext   = CW'(ring_length_r);
  assign len       = (len_ext < CW'(2)) ? LW'(2) :
                     (len_ext > CW'(DEPTH)) ? LW'(DEPTH) : LW'(len_ext);
  assign r_valid   = (32'(item_r.reader) < READERS);
  assign rsel      = RIW'(item_r.reader);
  assign mem_wdata = DATA_WIDTH'(item_r.write_data);
  assign cand      = (att_r[scan_idx_r] && (bl_r[scan_idx_r] > best_r)) ?
                     bl_r[scan_idx_r] : best_r;
  assign cfg_wr    = psel && penable && pwrite && (paddr == ADDR_RING_LENGTH);

  assign pready       = 1'b1;
  assign prdata       = (paddr == ADDR_RING_LENGTH) ? CFG_DW'(ring_length_r) : '0;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = READERS - 1; i >= 0; i--) begin
      if (!att_r[i]) begin
        free_any = 1'b1;
        free_idx = RIW'(i);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    att_nxt         = att_r;
    ptr_nxt         = ptr_r;
    bl_nxt          = bl_r;
    ring_length_nxt = ring_length_r;
    scan_idx_nxt    = scan_idx_r;
    best_nxt        = best_r;
    status_nxt      = status_r;
    slot_nxt        = slot_r;
    pidx_nxt        = pidx_r;
    pvalid_nxt      = pvalid_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = head_r;

    if (cfg_wr) begin
      ring_length_nxt = pwdata[COUNT_W-1:0];
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        slot_nxt   = item_r.reader;
        pidx_nxt   = rsel;
        pvalid_nxt = r_valid;
        state_nxt  = S_DONE;
        case (item_r.mode)
          MODE_WRITE: begin
            mem_we   = 1'b1;
            mem_addr = head_r;
            head_nxt = adv(head_r, len);
            fill_nxt = (fill_r >= len) ? len : fill_r + LW'(1);
            for (int i = 0; i < READERS; i++) begin
              if (att_r[i]) begin
                if (bl_r[i] >= len) begin
                  ptr_nxt[i] = adv(ptr_r[i], len);
                  bl_nxt[i]  = len;
                end else begin
                  bl_nxt[i]  = bl_r[i] + LW'(1);
                end
              end
            end
          end
          MODE_READ: begin
            if (!r_valid || !att_r[rsel]) begin
              status_nxt = ST_NOT_ATT;
            end else if (bl_r[rsel] == '0) begin
              status_nxt = ST_NO_DATA;
            end else begin
              mem_re        = 1'b1;
              mem_addr      = ptr_r[rsel];
              ptr_nxt[rsel] = adv(ptr_r[rsel], len);
              bl_nxt[rsel]  = bl_r[rsel] - LW'(1);
              scan_idx_nxt  = '0;
              best_nxt      = '0;
              state_nxt     = S_SCAN;
            end
          end
          MODE_ATTACH: begin
            if (free_any) begin
              att_nxt[free_idx] = 1'b1;
              ptr_nxt[free_idx] = head_r;
              bl_nxt[free_idx]  = '0;
              slot_nxt          = SLOT_W'(free_idx);
              pidx_nxt          = free_idx;
              pvalid_nxt        = 1'b1;
            end else begin
              status_nxt = ST_NO_SLOT;
              slot_nxt   = '0;
              pvalid_nxt = 1'b0;
            end
          end
          MODE_DETACH: begin
            if (!r_valid || !att_r[rsel]) begin
              status_nxt = ST_NOT_ATT;
            end else begin
              att_nxt[rsel] = 1'b0;
              ptr_nxt[rsel] = '0;
              bl_nxt[rsel]  = '0;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        best_nxt = cand;
        if (scan_idx_r == RIW'(READERS - 1)) begin
          fill_nxt  = (cand > len) ? len : cand;
          state_nxt = S_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + RIW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.status    = status_r;
          out_nxt.read_data = (item_r.mode == MODE_READ && status_r == ST_OK) ?
                              RDATA_W'(rd_q_r) : '0;
          out_nxt.slot      = slot_r;
          out_nxt.pending   = (pvalid_r && att_r[pidx_r]) ? COUNT_W'(bl_r[pidx_r]) : '0;
          out_nxt.fill      = COUNT_W'(fill_r);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      fill_r        <= '0;
      ring_length_r <= RING_LENGTH_RESET;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < READERS; i++) begin
        att_r[i] <= 1'b0;
        ptr_r[i] <= '0;
        bl_r[i]  <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      fill_r        <= fill_nxt;
      ring_length_r <= ring_length_nxt;
      out_valid_r   <= out_valid_nxt;
      att_r         <= att_nxt;
      ptr_r         <= ptr_nxt;
      bl_r          <= bl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_idx_r <= scan_idx_nxt;
    best_r     <= best_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    pidx_r     <= pidx_nxt;
    pvalid_r   <= pvalid_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_addr];
    end
  end

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  a_single_ram_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("RAM read and write in the same cycle");

  a_attach_grants_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && item_r.mode == MODE_ATTACH && free_any
    |=> att_r[$past(free_idx)] && bl_r[$past(free_idx)] == '0)
    else $error("attach did not claim the free slot");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_reader_overwrite_ring: drives write/read/attach/detach
// transactions, predicts every result in-bench and compares it field by field.
// Depends on mrr_pkg, mrr_stream_if and the multi_reader_overwrite_ring RTL.
module testbench;
  import mrr_pkg::*;

  localparam int RING_DEPTH    = 4096;
  localparam int NUM_READERS   = 8;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  mrr_stream_if #(.T(in_item_t))  in_ch ();
  mrr_stream_if #(.T(out_item_t)) out_ch ();

  multi_reader_overwrite_ring #(
    .DEPTH      (RING_DEPTH),
    .READERS    (NUM_READERS),
    .DATA_WIDTH (8)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // ring state as the block should hold it
  logic [7:0]   ring_mem [RING_DEPTH];
  bit           ring_mem_written [RING_DEPTH];
  logic [11:0]  wr_pos = '0;
  logic [11:0]  oldest_pos = '0;
  logic [12:0]  held_count = '0;
  bit           rd_live [NUM_READERS];
  logic [11:0]  rd_ptr [NUM_READERS] = '{default: '0};
  logic [12:0]  rd_lag [NUM_READERS] = '{default: '0};
  logic [12:0]  ring_len_reg = RING_LENGTH_RESET;

  out_item_t answer_q [$];
  int fail_count = 0;
  int cycle_count = 0;
  int mode_tally [4] = '{default: 0};
  int status_tally [4] = '{default: 0};
  int overwrite_count = 0;
  int config_writes = 0;
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;

  function automatic logic [11:0] next_pos(logic [11:0] p, logic [12:0] len);
    return ({1'b0, p} + 13'd1 >= len) ? 12'd0 : p + 12'd1;
  endfunction

  function automatic out_item_t ring_op_outcome(in_item_t item);
    out_item_t res;
    logic [12:0] len;
    bit slot_ok;
    bit found;
    int best;
    int i;
    len = (ring_len_reg < 13'd2) ? 13'd2 :
          (ring_len_reg > 13'(RING_DEPTH)) ? 13'(RING_DEPTH) : ring_len_reg;
    res.status = ST_OK;
    res.read_data = '0;
    res.slot = item.reader;
    slot_ok = 1'b1;
    case (item.mode)
      MODE_WRITE: begin
        if (held_count >= len) begin
          oldest_pos = next_pos(wr_pos, len);
          held_count = len - 13'd1;
          overwrite_count++;
        end
        for (i = 0; i < NUM_READERS; i++) begin
          if (rd_live[i] && rd_lag[i] >= len) begin
            rd_ptr[i] = next_pos(rd_ptr[i], len);
            rd_lag[i] = len - 13'd1;
          end
        end
        ring_mem[wr_pos] = item.write_data;
        ring_mem_written[wr_pos] = 1'b1;
        wr_pos = next_pos(wr_pos, len);
        held_count = held_count + 13'd1;
        for (i = 0; i < NUM_READERS; i++)
          if (rd_live[i]) rd_lag[i] = rd_lag[i] + 13'd1;
      end
      MODE_READ: begin
        if (!rd_live[item.reader]) begin
          res.status = ST_NOT_ATT;
        end else if (rd_lag[item.reader] == '0) begin
          res.status = ST_NO_DATA;
        end else begin
          res.read_data = ring_mem[rd_ptr[item.reader]];
          rd_ptr[item.reader] = next_pos(rd_ptr[item.reader], len);
          rd_lag[item.reader] = rd_lag[item.reader] - 13'd1;
          found = 1'b0;
          best = 0;
          for (i = 0; i < NUM_READERS; i++) begin
            if (rd_live[i] && (!found || rd_lag[i] > rd_lag[best])) begin
              best = i;
              found = 1'b1;
            end
          end
          oldest_pos = rd_ptr[best];
          held_count = (rd_lag[best] > len) ? len : rd_lag[best];
        end
      end
      MODE_ATTACH: begin
        slot_ok = 1'b0;
        for (i = 0; i < NUM_READERS; i++) begin
          if (!slot_ok && !rd_live[i]) begin
            rd_live[i] = 1'b1;
            rd_ptr[i] = wr_pos;
            rd_lag[i] = '0;
            res.slot = i[2:0];
            slot_ok = 1'b1;
          end
        end
        if (!slot_ok) begin
          res.status = ST_NO_SLOT;
          res.slot = '0;
        end
      end
      default: begin
        if (!rd_live[item.reader]) begin
          res.status = ST_NOT_ATT;
        end else begin
          rd_live[item.reader] = 1'b0;
          rd_ptr[item.reader] = '0;
          rd_lag[item.reader] = '0;
        end
      end
    endcase
    res.pending = (slot_ok && rd_live[res.slot]) ? rd_lag[res.slot] : '0;
    res.fill = held_count;
    status_tally[res.status]++;
    return res;
  endfunction

  function automatic in_item_t make_op(mode_t m, logic [2:0] r, logic [7:0] d);
    in_item_t it;
    it.mode = m;
    it.reader = r;
    it.write_data = d;
    return it;
  endfunction

  function automatic in_item_t next_traffic_item();
    in_item_t it;
    int live_slots [$];
    int roll;
    int i;
    it = make_op(MODE_WRITE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    for (i = 0; i < NUM_READERS; i++)
      if (rd_live[i]) live_slots.push_back(i);
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      it.mode = MODE_WRITE;
    end else if (roll < 78) begin
      it.mode = MODE_READ;
      if (live_slots.size() > 0 && roll < 74)
        it.reader = 3'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
    end else if (roll < 90) begin
      it.mode = MODE_ATTACH;
    end else begin
      it.mode = MODE_DETACH;
    end
    // keep reads off entries that were never stored
    if (it.mode == MODE_READ && rd_live[it.reader] && rd_lag[it.reader] != '0 &&
        !ring_mem_written[rd_ptr[it.reader]])
      it.mode = MODE_WRITE;
    return it;
  endfunction

  task automatic send_op(in_item_t item);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = item;
    do @(posedge clk); while (!in_ch.ready);
    answer_q.push_back(ring_op_outcome(item));
    mode_tally[item.mode]++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic run_traffic(int count);
    repeat (count) send_op(next_traffic_item());
  endtask

  task automatic drain_answers();
    while (answer_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic await_quiet();
    drain_answers();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_ring_length(logic [31:0] word);
    await_quiet();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_RING_LENGTH;
    pwdata = word;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    ring_len_reg = word[12:0];
    config_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_directed_ops();
    int i;
    send_op(make_op(MODE_READ, 3'd0, 8'h00));
    send_op(make_op(MODE_DETACH, 3'd5, 8'h00));
    send_op(make_op(MODE_ATTACH, 3'd0, 8'h00));
    send_op(make_op(MODE_READ, 3'd0, 8'h00));
    send_op(make_op(MODE_WRITE, 3'd0, 8'h00));
    send_op(make_op(MODE_WRITE, 3'd7, 8'hFF));
    send_op(make_op(MODE_ATTACH, 3'd0, 8'h00));
    send_op(make_op(MODE_WRITE, 3'd1, 8'h5A));
    send_op(make_op(MODE_READ, 3'd0, 8'h00));
    send_op(make_op(MODE_READ, 3'd0, 8'h00));
    send_op(make_op(MODE_READ, 3'd1, 8'h00));
    send_op(make_op(MODE_READ, 3'd0, 8'h00));
    send_op(make_op(MODE_READ, 3'd0, 8'h00));
    for (i = 0; i < 7; i++)
      send_op(make_op(MODE_ATTACH, 3'(i), 8'h00));
    send_op(make_op(MODE_DETACH, 3'd7, 8'h00));
    send_op(make_op(MODE_DETACH, 3'd3, 8'h00));
    send_op(make_op(MODE_ATTACH, 3'd0, 8'h00));
    send_op(make_op(MODE_WRITE, 3'd3, 8'hA5));
    send_op(make_op(MODE_READ, 3'd7, 8'h00));
  endtask

  task automatic test_ring_length_edges();
    logic [12:0] len_points [7] = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd8191, 13'd4097, 13'd4096};
    logic [31:0] word;
    int k;
    for (k = 0; k < 7; k++) begin
      word = $urandom;
      word[12:0] = len_points[k];
      set_ring_length(word);
      run_traffic(14);
    end
  endtask

  task automatic test_random_traffic();
    logic [12:0] len_plan [6];
    int k;
    len_plan = '{13'($urandom_range(2, 6)), 13'($urandom_range(2, 12)),
                 13'($urandom_range(13, 64)), 13'd4096,
                 13'($urandom_range(2, 8)), 13'($urandom_range(3, 40))};
    for (k = 0; k < 6; k++) begin
      set_ring_length({19'd0, len_plan[k]});
      run_traffic(100);
    end
  endtask

  task automatic test_output_backpressure();
    set_ring_length(32'($urandom_range(2, 10)));
    hold_req = 1'b1;
    run_traffic(50);
    drain_answers();
    run_traffic(30);
  endtask

  task automatic test_steady_stream();
    set_ring_length(32'($urandom_range(2, 16)));
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    run_traffic(120);
  endtask

  initial begin : result_sink
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        stall_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (answer_q.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", got.status, got.slot);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
          fail_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          fail_count++;
        end
        if (got.pending !== want.pending) begin
          $error("pending: expected %0d, got %0d", want.pending, got.pending);
          fail_count++;
        end
        if (got.fill !== want.fill) begin
          $error("fill: expected %0d, got %0d", want.fill, got.fill);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_ring_length_edges();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();
    await_quiet();

    $display("summary: %0d transactions (write %0d, read %0d, attach %0d, detach %0d)",
             mode_tally[MODE_WRITE] + mode_tally[MODE_READ] +
             mode_tally[MODE_ATTACH] + mode_tally[MODE_DETACH],
             mode_tally[MODE_WRITE], mode_tally[MODE_READ],
             mode_tally[MODE_ATTACH], mode_tally[MODE_DETACH]);
    $display(
      "summary: %0d length writes, %0d overwrites, ok/empty/unattached/full %0d/%0d/%0d/%0d",
      config_writes, overwrite_count, status_tally[ST_OK], status_tally[ST_NO_DATA],
      status_tally[ST_NOT_ATT], status_tally[ST_NO_SLOT]);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
sv/mrr_pkg.sv
sv/mrr_stream_if.sv
sv/multi_reader_overwrite_ring.sv
tb/sv/testbench.sv
